FILE: sv/evad_pkg.sv
// shared types, constants and register codes of the energy voice activity detector
package evad_pkg;

   localparam int MAX_FRAME_SAMPLES_DEFAULT = 1024;

   localparam int ENERGY_W = 31;
   localparam int SQUARE_W = 31;
   localparam int THR_W = 15;
   localparam int THR_SQ_W = 30;
   localparam int RUN_W = 8;
   localparam int MS_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_ENERGY_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_SPEECH_FRAMES_NEEDED = 2'd1;
   localparam logic [1:0] REG_SILENCE_TIMEOUT_MS = 2'd2;
   localparam logic [1:0] REG_MIN_SPEECH_MS = 2'd3;

   localparam logic [14:0] ENERGY_THRESHOLD_RESET = 15'd500;
   localparam logic [7:0] SPEECH_FRAMES_NEEDED_RESET = 8'd3;
   localparam logic [15:0] SILENCE_TIMEOUT_MS_RESET = 16'd1000;
   localparam logic [15:0] MIN_SPEECH_MS_RESET = 16'd500;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_SPEAKING = 2'd1,
      MODE_TRAILING = 2'd2
   } vad_mode_type;

   typedef struct packed {
      logic [14:0] energy_threshold;
      logic [7:0] speech_frames_needed;
      logic [15:0] silence_timeout_ms;
      logic [15:0] min_speech_ms;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic square;
      logic accum;
      logic div_start;
      logic decide;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic frame_last;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

FILE: sv/evad_csr.sv
// configuration register file with apb-style access
module evad_csr (
   input logic clock,
   input logic reset,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [evad_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [evad_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [evad_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output evad_pkg::cfg_type cfg
);
   import evad_pkg::*;

   cfg_type cfg_ff;
   logic [1:0] index;
   logic write_en;

   assign index = csr_paddr[3:2];
   assign write_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.energy_threshold <= ENERGY_THRESHOLD_RESET;
         cfg_ff.speech_frames_needed <= SPEECH_FRAMES_NEEDED_RESET;
         cfg_ff.silence_timeout_ms <= SILENCE_TIMEOUT_MS_RESET;
         cfg_ff.min_speech_ms <= MIN_SPEECH_MS_RESET;
      end else if (write_en) begin
         unique case (index)
            REG_ENERGY_THRESHOLD: cfg_ff.energy_threshold <= csr_pwdata[14:0];
            REG_SPEECH_FRAMES_NEEDED: cfg_ff.speech_frames_needed <= csr_pwdata[7:0];
            REG_SILENCE_TIMEOUT_MS: cfg_ff.silence_timeout_ms <= csr_pwdata[15:0];
            REG_MIN_SPEECH_MS: cfg_ff.min_speech_ms <= csr_pwdata[15:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_ENERGY_THRESHOLD: csr_prdata = {17'b0, cfg_ff.energy_threshold};
         REG_SPEECH_FRAMES_NEEDED: csr_prdata = {24'b0, cfg_ff.speech_frames_needed};
         REG_SILENCE_TIMEOUT_MS: csr_prdata = {16'b0, cfg_ff.silence_timeout_ms};
         REG_MIN_SPEECH_MS: csr_prdata = {16'b0, cfg_ff.min_speech_ms};
         default: csr_prdata = '0;
      endcase
   end

endmodule

FILE: sv/evad_divider.sv
// bit-serial restoring divider for the frame mean square
module evad_divider #(
   parameter int SUM_W = 41,
   parameter int CNT_W = 11
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [SUM_W-1:0] dividend,
   input logic [CNT_W-1:0] divisor,
   output logic last,
   output logic [SUM_W-1:0] quotient
);
   localparam int STEP_W = $clog2(SUM_W + 1);

   logic busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] divisor_ff, divisor_in;
   logic [CNT_W:0] shifted;
   logic [CNT_W:0] diff;
   logic fits;

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign diff = shifted - {1'b0, divisor_ff};
   assign fits = shifted >= {1'b0, divisor_ff};
   assign last = busy_ff && (step_ff == STEP_W'(1));
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W);
         rem_in = '0;
         quo_in = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         step_in = step_ff - STEP_W'(1);
         busy_in = (step_ff != STEP_W'(1));
         rem_in = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      divisor_ff <= divisor_in;
   end

endmodule

FILE: sv/evad_datapath.sv
// sample accumulator, frame decision, detector mode and result register
module evad_datapath #(
   parameter int MAX_FRAME_SAMPLES = evad_pkg::MAX_FRAME_SAMPLES_DEFAULT
) (
   input logic clock,
   input logic reset,
   input evad_pkg::cmd_type cmd,
   output evad_pkg::status_type status,
   input evad_pkg::cfg_type cfg,
   input logic req_op,
   input logic signed [15:0] req_sample,
   input logic req_frame_last,
   input logic [31:0] req_now_ms,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [1:0] rsp_vad_state,
   output logic rsp_frame_is_speech,
   output logic [30:0] rsp_frame_energy
);
   import evad_pkg::*;

   localparam int SUM_W = SQUARE_W + $clog2(MAX_FRAME_SAMPLES);
   localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);

   logic op_ff;
   logic signed [15:0] sample_ff;
   logic frame_last_ff;
   logic [MS_W-1:0] now_ff;

   logic [SQUARE_W-1:0] square_ff;
   logic [THR_SQ_W-1:0] thr_sq_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0] count_ff;

   vad_mode_type mode_ff, mode_in;
   logic [RUN_W-1:0] run_ff, run_in, run_inc;
   logic [MS_W-1:0] start_ff, start_in, last_ff, last_in;

   logic rsp_valid_ff;
   logic [1:0] rsp_vad_state_ff;
   logic rsp_frame_is_speech_ff;
   logic [ENERGY_W-1:0] rsp_frame_energy_ff;

   logic [16:0] ext, mag;
   logic [33:0] prod;
   logic [SUM_W-1:0] quotient;
   logic div_last;
   logic [ENERGY_W-1:0] energy;
   logic speech;
   logic [MS_W-1:0] silence, duration;
   logic room;

   evad_divider #(
      .SUM_W(SUM_W),
      .CNT_W(CNT_W)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .start(cmd.div_start),
      .dividend(sum_ff),
      .divisor(count_ff),
      .last(div_last),
      .quotient(quotient)
   );

   assign ext = {sample_ff[15], sample_ff};
   assign mag = sample_ff[15] ? 17'(~ext + 17'd1) : ext;
   assign prod = {17'b0, mag} * {17'b0, mag};
   assign room = count_ff < CNT_W'(MAX_FRAME_SAMPLES);

   assign energy = quotient[ENERGY_W-1:0];
   assign speech = energy > {1'b0, thr_sq_ff};
   assign silence = now_ff - last_ff;
   assign duration = now_ff - start_ff;
   assign run_inc = (run_ff == {RUN_W{1'b1}}) ? run_ff : run_ff + RUN_W'(1);

   assign status.op = op_ff;
   assign status.frame_last = frame_last_ff;
   assign status.div_last = div_last;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_vad_state = rsp_vad_state_ff;
   assign rsp_frame_is_speech = rsp_frame_is_speech_ff;
   assign rsp_frame_energy = rsp_frame_energy_ff;

   always_comb begin
      mode_in = mode_ff;
      run_in = run_ff;
      start_in = start_ff;
      last_in = last_ff;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (speech) begin
               run_in = run_inc;
               if (run_inc >= cfg.speech_frames_needed) begin
                  mode_in = MODE_SPEAKING;
                  start_in = now_ff;
                  last_in = now_ff;
               end
            end else begin
               run_in = '0;
            end
         end
         MODE_SPEAKING: begin
            if (speech) begin
               last_in = now_ff;
            end else if (silence > {16'b0, cfg.silence_timeout_ms}) begin
               if (duration >= {16'b0, cfg.min_speech_ms}) begin
                  mode_in = MODE_TRAILING;
               end else begin
                  mode_in = MODE_IDLE;
                  run_in = '0;
               end
            end
         end
         MODE_TRAILING: begin
            mode_in = mode_ff;
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         sample_ff <= req_sample;
         frame_last_ff <= req_frame_last;
         now_ff <= req_now_ms;
      end
      if (cmd.square) begin
         square_ff <= prod[SQUARE_W-1:0];
         thr_sq_ff <= THR_SQ_W'(cfg.energy_threshold) * THR_SQ_W'(cfg.energy_threshold);
      end
      if (cmd.decide) begin
         rsp_vad_state_ff <= mode_in;
         rsp_frame_is_speech_ff <= speech;
         rsp_frame_energy_ff <= energy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         mode_ff <= MODE_IDLE;
         run_ff <= '0;
         start_ff <= '0;
         last_ff <= '0;
         sum_ff <= '0;
         count_ff <= '0;
      end else if (cmd.decide) begin
         mode_ff <= mode_in;
         run_ff <= run_in;
         start_ff <= start_in;
         last_ff <= last_in;
         sum_ff <= '0;
         count_ff <= '0;
      end else if (cmd.accum && room) begin
         sum_ff <= sum_ff + SUM_W'(square_ff);
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.decide) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FRAME_SAMPLES))
      else $error("frame sample count beyond frame limit");

   count_nonzero_at_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> count_ff != '0)
      else $error("divide started with empty frame");

endmodule

FILE: sv/evad_controller.sv
// sequencing state machine for request handling and frame decision
module evad_controller (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input evad_pkg::status_type status,
   output evad_pkg::cmd_type cmd
);
   import evad_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ACCUM,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_DECIDE
   } state_type;

   state_type state_ff, state_in;
   logic stall_ff;
   logic accept;

   assign req_stall = stall_ff;
   assign accept = req_valid && !stall_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.op) begin
               cmd.clear = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.square = 1'b1;
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in = status.frame_last ? ST_DIV_LOAD : ST_IDLE;
         end
         ST_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.out_free) begin
               cmd.decide = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= (state_in != ST_IDLE);
      end
   end

   accept_starts_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted request did not start execution");

   busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> stall_ff)
      else $error("request channel open while busy");

   decide_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> status.out_free)
      else $error("result written over pending result");

endmodule

FILE: sv/energy_voice_activity_detector_core.sv
// top level of the energy voice activity detector
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   op, sample, frame_last, now_ms
//   rsp       out        rsp_valid/rsp_stall   vad_state, frame_is_speech, frame_energy
//   csr       in         apb-style, pready=1   energy_threshold .. min_speech_ms
//
// a sample request passes through capture, square and accumulate
// a frame's last sample then starts the bit-serial divider that forms the mean
// square, and the decision waits until the divider ends and the output is free
// restart clears detector state; reset is synchronous and needs no clearing pass
// a stalled result stays in the output register while the next request proceeds
module energy_voice_activity_detector_core #(
   parameter int MAX_FRAME_SAMPLES = evad_pkg::MAX_FRAME_SAMPLES_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic req_op,
   input logic signed [15:0] req_sample,
   input logic req_frame_last,
   input logic [31:0] req_now_ms,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [1:0] rsp_vad_state,
   output logic rsp_frame_is_speech,
   output logic [30:0] rsp_frame_energy,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [evad_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [evad_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [evad_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import evad_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   status_type status;

   evad_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   evad_controller u_controller (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status(status),
      .cmd(cmd)
   );

   evad_datapath #(
      .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .cfg(cfg),
      .req_op(req_op),
      .req_sample(req_sample),
      .req_frame_last(req_frame_last),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_vad_state(rsp_vad_state),
      .rsp_frame_is_speech(rsp_frame_is_speech),
      .rsp_frame_energy(rsp_frame_energy)
   );

endmodule

FILE: tb/tb.sv
// self-checking testbench for the energy voice activity detector core
`timescale 1ns / 1ps

module tb;
   import evad_pkg::*;

   typedef struct packed {
      logic op;
      logic [15:0] sample;
      logic frame_last;
      logic [31:0] now_ms;
   } audio_req_t;

   typedef struct packed {
      logic [1:0] vad_state;
      logic is_speech;
      logic [30:0] energy;
   } frame_result_t;

   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = 1'b0;
   logic [15:0] req_sample = '0;
   logic req_frame_last = 1'b0;
   logic [31:0] req_now_ms = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_vad_state;
   logic rsp_frame_is_speech;
   logic [30:0] rsp_frame_energy;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   energy_voice_activity_detector_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_sample(req_sample),
      .req_frame_last(req_frame_last),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_vad_state(rsp_vad_state),
      .rsp_frame_is_speech(rsp_frame_is_speech),
      .rsp_frame_energy(rsp_frame_energy),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   audio_req_t pending_reqs[$];
   frame_result_t expected_frames[$];
   bit steady_flow = 1'b0;
   int hold_armed = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int mismatch_count = 0;
   int reqs_queued = 0;
   int reqs_accepted = 0;
   int frames_checked = 0;
   int speaking_frames = 0;
   int trailing_frames = 0;
   logic [31:0] clock_ms = '0;

   // predictor state and register copy
   cfg_type cfg_now = '{ENERGY_THRESHOLD_RESET, SPEECH_FRAMES_NEEDED_RESET,
                        SILENCE_TIMEOUT_MS_RESET, MIN_SPEECH_MS_RESET};
   vad_mode_type mode_now = MODE_IDLE;
   logic [7:0] run_count = '0;
   logic [31:0] utter_start = '0;
   logic [31:0] last_speech = '0;
   logic [40:0] square_total = '0;
   logic [10:0] sample_total = '0;

   task automatic predict_vad(input logic op, input logic [15:0] sample,
                              input logic last, input logic [31:0] now);
      logic [16:0] mag;
      logic [40:0] mean;
      logic [29:0] thr_sq;
      logic [31:0] silence_ms;
      logic [31:0] span_ms;
      logic speech;
      frame_result_t res;
      if (op) begin
         mode_now = MODE_IDLE;
         run_count = '0;
         utter_start = '0;
         last_speech = '0;
         square_total = '0;
         sample_total = '0;
      end else begin
         mag = sample[15] ? 17'h10000 - {1'b0, sample} : {1'b0, sample};
         if (sample_total < 11'd1024) begin
            square_total = square_total + mag * mag;
            sample_total = sample_total + 11'd1;
         end
         if (last) begin
            mean = square_total / sample_total;
            thr_sq = cfg_now.energy_threshold * cfg_now.energy_threshold;
            speech = mean > thr_sq;
            silence_ms = now - last_speech;
            span_ms = now - utter_start;
            if (mode_now == MODE_IDLE) begin
               if (speech) begin
                  if (run_count != 8'd255) run_count = run_count + 8'd1;
                  if (run_count >= cfg_now.speech_frames_needed) begin
                     mode_now = MODE_SPEAKING;
                     utter_start = now;
                     last_speech = now;
                  end
               end else begin
                  run_count = '0;
               end
            end else if (mode_now == MODE_SPEAKING) begin
               if (speech) begin
                  last_speech = now;
               end else if (silence_ms > {16'd0, cfg_now.silence_timeout_ms}) begin
                  if (span_ms >= {16'd0, cfg_now.min_speech_ms}) begin
                     mode_now = MODE_TRAILING;
                  end else begin
                     mode_now = MODE_IDLE;
                     run_count = '0;
                  end
               end
            end
            square_total = '0;
            sample_total = '0;
            res.vad_state = mode_now;
            res.is_speech = speech;
            res.energy = mean[30:0];
            expected_frames.push_back(res);
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin
      audio_req_t r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() != 0 && (steady_flow || $urandom_range(99) >= 17)) begin
            r = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_op <= r.op;
            req_sample <= r.sample;
            req_frame_last <= r.frame_last;
            req_now_ms <= r.now_ms;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_vad(req_op, req_sample, req_frame_last, req_now_ms);
         reqs_accepted++;
      end
   end

   // result receiver, with a long hold-off when armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_armed) begin
         rsp_stall <= 1'b1;
         hold_seen <= hold_armed;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_stall <= !steady_flow && ($urandom_range(99) < 17);
      end
   end

   always @(posedge clock) begin
      frame_result_t exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            $display("%0t: unexpected result state %0d speech %0d energy %0d", $time,
                     rsp_vad_state, rsp_frame_is_speech, rsp_frame_energy);
            mismatch_count++;
         end else begin
            exp_res = expected_frames.pop_front();
            frames_checked++;
            if (rsp_vad_state !== exp_res.vad_state) begin
               $display("%0t: vad_state expected %0d, got %0d", $time,
                        exp_res.vad_state, rsp_vad_state);
               mismatch_count++;
            end
            if (rsp_frame_is_speech !== exp_res.is_speech) begin
               $display("%0t: frame_is_speech expected %0d, got %0d", $time,
                        exp_res.is_speech, rsp_frame_is_speech);
               mismatch_count++;
            end
            if (rsp_frame_energy !== exp_res.energy) begin
               $display("%0t: frame_energy expected %0d, got %0d", $time,
                        exp_res.energy, rsp_frame_energy);
               mismatch_count++;
            end
            if (exp_res.vad_state == MODE_SPEAKING) speaking_frames++;
            if (exp_res.vad_state == MODE_TRAILING) trailing_frames++;
         end
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_ENERGY_THRESHOLD: cfg_now.energy_threshold = value[14:0];
         REG_SPEECH_FRAMES_NEEDED: cfg_now.speech_frames_needed = value[7:0];
         REG_SILENCE_TIMEOUT_MS: cfg_now.silence_timeout_ms = value[15:0];
         REG_MIN_SPEECH_MS: cfg_now.min_speech_ms = value[15:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [14:0] thr, input logic [7:0] need,
                            input logic [15:0] timeout_ms, input logic [15:0] min_ms);
      write_csr(REG_ENERGY_THRESHOLD, {17'd0, thr});
      write_csr(REG_SPEECH_FRAMES_NEEDED, {24'd0, need});
      write_csr(REG_SILENCE_TIMEOUT_MS, {16'd0, timeout_ms});
      write_csr(REG_MIN_SPEECH_MS, {16'd0, min_ms});
      clock_ms = $urandom;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_frames.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic push_req(input logic op, input logic [15:0] sample, input logic last,
                           input logic [31:0] now);
      audio_req_t r;
      r.op = op;
      r.sample = sample;
      r.frame_last = last;
      r.now_ms = now;
      pending_reqs.push_back(r);
      reqs_queued++;
   endtask

   // loud samples sit above the threshold, quiet ones at or below it
   function automatic logic [15:0] pick_sample(input bit loud);
      int unsigned thr;
      int unsigned mag;
      logic [15:0] s;
      thr = 32'(cfg_now.energy_threshold);
      if (loud) mag = ($urandom_range(3) == 0) ? thr + 1 : $urandom_range(32768, thr + 1);
      else mag = ($urandom_range(3) == 0) ? thr : $urandom_range(thr, 0);
      s = mag[15:0];
      if ($urandom_range(1) != 0) s = -s;
      return s;
   endfunction

   function automatic int frame_len();
      return ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
   endfunction

   task automatic push_frame(input int len, input bit loud, input logic [31:0] now);
      for (int i = 1; i <= len; i++) push_req(1'b0, pick_sample(loud), i == len,
                                              (i == len) ? now : $urandom);
   endtask

   task automatic tick_clock();
      int unsigned tmo;
      tmo = 32'(cfg_now.silence_timeout_ms);
      if ($urandom_range(3) == 0) clock_ms += $urandom_range(2 * tmo + 100);
      else clock_ms += $urandom_range(tmo / 4 + 20);
   endtask

   // utterances with random content, plus noise frames and restarts
   task automatic talk(input int n);
      int stop_at;
      int k;
      int len;
      stop_at = reqs_queued + n;
      while (reqs_queued < stop_at) begin
         k = $urandom_range(99);
         if (k < 6) begin
            push_req(1'b1, 16'($urandom), 1'($urandom_range(1)), $urandom);
         end else if (k < 14) begin
            len = frame_len();
            for (int i = 1; i <= len; i++) push_req(1'b0, 16'($urandom), i == len, $urandom);
         end else begin
            repeat ($urandom_range(int'(cfg_now.speech_frames_needed) + 2, 1)) begin
               tick_clock();
               push_frame(frame_len(), 1'b1, clock_ms);
            end
            repeat ($urandom_range(6)) begin
               tick_clock();
               push_frame(frame_len(), 1'b0, clock_ms);
            end
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: speech entry, exact timeout, trailing, timestamp wrap, long frame
      push_req(1'b1, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
      push_req(1'b0, 16'h8000, 1'b1, 32'd0);
      push_req(1'b0, 16'h7FFF, 1'b1, 32'd10);
      push_req(1'b0, 16'd500, 1'b0, 32'd0);
      push_req(1'b0, 16'd501, 1'b1, 32'd20);
      push_req(1'b0, 16'd3, 1'b0, 32'd0);
      push_req(1'b0, 16'hFFFC, 1'b1, 32'd1020);
      push_req(1'b0, 16'hFE0C, 1'b1, 32'd1021);
      push_req(1'b0, 16'h8000, 1'b1, 32'd5000);
      push_req(1'b1, 16'h0000, 1'b0, 32'd0);
      push_req(1'b0, 16'h8001, 1'b1, 32'hFFFF_FFF0);
      push_req(1'b0, 16'h4000, 1'b1, 32'hFFFF_FFF8);
      push_req(1'b0, 16'hC000, 1'b1, 32'hFFFF_FFFC);
      push_req(1'b0, 16'h0000, 1'b1, 32'd998);
      push_req(1'b1, 16'h5555, 1'b0, 32'h5555_5555);
      for (int i = 1; i <= 1030; i++) begin
         push_req(1'b0, (i > 1024) ? 16'h8000 : 16'h0000, i == 1030, 32'hAAAA_AAAA);
      end
      push_req(1'b0, 16'h0000, 1'b1, 32'd0);
      talk(90);
      wait_idle();

      configure(15'd0, 8'd0, 16'd0, 16'd0);
      talk(90);
      wait_idle();

      configure(15'd32767, 8'd1, 16'd65535, 16'd65535);
      talk(70);
      wait_idle();

      steady_flow <= 1'b1;
      configure(15'd1000, 8'd2, 16'd300, 16'd2000);
      talk(100);
      wait_idle();

      // receiver holds off while short frames keep coming
      configure(15'd200, 8'd1, 16'd100, 16'd50);
      hold_armed <= hold_armed + 1;
      repeat (60) begin
         tick_clock();
         push_frame(1, 1'($urandom_range(1)), clock_ms);
      end
      wait_idle();
      steady_flow <= 1'b0;
      talk(60);
      wait_idle();

      // longest speech run needed to start speaking
      configure(15'd0, 8'd255, 16'd0, 16'd0);
      repeat (256) begin
         clock_ms += $urandom_range(3);
         push_frame(1, 1'b1, clock_ms);
      end
      push_frame(1, 1'b0, clock_ms + 32'd5);
      push_req(1'b1, 16'($urandom), 1'b0, $urandom);
      repeat (10) push_frame(2, 1'($urandom_range(1)), clock_ms);
      wait_idle();

      configure(15'($urandom_range(3000)), 8'($urandom_range(4, 1)),
                16'($urandom_range(2000)), 16'($urandom_range(3000)));
      talk(60);
      wait_idle();

      $display("covered %0d requests and %0d frame results (%0d speaking, %0d trailing)",
               reqs_accepted, frames_checked, speaking_frames, trailing_frames);
      $display("register extremes, restarts, overlong frame and a long result hold-off run");
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", expected_frames.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: sim.f
sv/evad_pkg.sv
sv/evad_csr.sv
sv/evad_divider.sv
sv/evad_datapath.sv
sv/evad_controller.sv
sv/energy_voice_activity_detector_core.sv
tb/tb.sv
